// ===== design/hta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hta_pkg;

  localparam int unsigned HTA_ENTRIES = 256;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned TAG_W       = 16;
  localparam logic [TAG_W-1:0] TAG_RESET = 16'h6800;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LOOK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] handle;
    logic [DATA_W-1:0] data;
  } res_t;

endpackage

`default_nettype wire

// ===== design/hta_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hta_slot_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/hta_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hta_ctrl
  import hta_pkg::*;
#(
  parameter int unsigned ENTRIES = HTA_ENTRIES
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [DATA_W-1:0] handle_i,
  input  wire logic [DATA_W-1:0] user_data_i,
  input  wire logic [TAG_W-1:0]  tag_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned PW = $clog2(ENTRIES + 1);

  state_e          state_q, state_d;
  logic [PW-1:0]   ptr_q;
  logic [PW-1:0]   scan_q;
  logic            chk_v_q;
  logic [AW-1:0]   chk_addr_q;
  logic [DATA_W-1:0] data_q;
  res_t            res_q;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              accept;
  cmd_e              cmd;
  logic [DATA_W-1:0] dec;
  logic [15:0]       idx16;
  logic              in_range;
  logic              tag_ok;
  logic              hit;
  logic              scan_end;
  logic              fail;
  logic              clr_last;
  logic [PW-1:0]     start;

  hta_slot_ram #(
    .DEPTH(ENTRIES),
    .AW   (AW),
    .DW   (DATA_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign cmd      = cmd_e'(cmd_i);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign dec      = handle_i - 32'd1;
  assign idx16    = dec[15:0];
  assign in_range = idx16 < 16'(ENTRIES);
  assign tag_ok   = dec[31:16] == tag_i;
  assign hit      = chk_v_q && (mem_rdata == '0);
  assign scan_end = scan_q == PW'(ENTRIES);
  assign fail     = scan_end && chk_v_q && !hit;
  assign clr_last = scan_q == PW'(ENTRIES - 1);
  // Wrap the next-fit pointer once it sits on the last slot or beyond.
  assign start    = (ptr_q >= PW'(ENTRIES - 1)) ? '0 : ptr_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_ALLOC:  state_d = ST_SCAN;
            CMD_LOOKUP: state_d = (tag_ok && in_range) ? ST_LOOK : ST_FIN;
            default:    state_d = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit || fail) state_d = ST_FIN;
      end
      ST_LOOK: state_d = ST_FIN;
      ST_FIN: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx16[AW-1:0];
    mem_wdata   = '0;
    mem_raddr   = idx16[AW-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_q[AW-1:0];
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_we     = accept && (cmd == CMD_FREE) && in_range;
      end
      ST_SCAN: begin
        mem_raddr = scan_q[AW-1:0];
        mem_we    = hit;
        mem_waddr = chk_addr_q;
        mem_wdata = data_q;
      end
      ST_FIN: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
      scan_q  <= '0;
      chk_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_CLEAR: scan_q <= scan_q + PW'(1);
        ST_IDLE: begin
          if (accept && (cmd == CMD_ALLOC)) begin
            ptr_q   <= start;
            scan_q  <= start;
            chk_v_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            ptr_q <= PW'(chk_addr_q) + PW'(1);
          end else if (!scan_end) begin
            chk_v_q <= 1'b1;
            scan_q  <= scan_q + PW'(1);
          end else begin
            chk_v_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          data_q       <= user_data_i;
          res_q.ok     <= (cmd == CMD_FREE) && in_range;
          res_q.handle <= '0;
          res_q.data   <= '0;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_q.ok     <= 1'b1;
          res_q.handle <= {tag_i, 16'(chk_addr_q) + 16'd1};
        end else if (!scan_end) begin
          chk_addr_q <= scan_q[AW-1:0];
        end
      end
      ST_LOOK: begin
        res_q.ok   <= 1'b1;
        res_q.data <= mem_rdata;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== design/handle_table_allocator.sv =====
// Next-fit handle table: ENTRIES slots of 32-bit user data, zero marking a free
// slot. Each item carries a command (allocate, free, look up) and yields exactly
// one result item. Allocate wraps the next-fit pointer to slot 0 when it has
// reached the last slot, then scans upward without wrapping, one slot per cycle
// through the single read port of the slot memory; a hit stores the data and
// returns {tag_high, index+1}. The block takes one item at a time and holds
// in_ready_o low until the item's result has moved into the output register,
// which lets the next item start while that result waits for out_ready_i. After
// reset a clearing pass writes zero to every slot, during which no item is
// accepted; the tag register (reset 16'h6800) can be written at any time over
// the cfg channel.
`timescale 1ns / 1ps
`default_nettype none

module handle_table_allocator
  import hta_pkg::*;
#(
  parameter int unsigned ENTRIES = HTA_ENTRIES
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command items
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [DATA_W-1:0] handle_i,
  input  wire logic [DATA_W-1:0] user_data_i,
  // result items
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   ok_o,
  output logic      [DATA_W-1:0] handle_out_o,
  output logic      [DATA_W-1:0] user_data_out_o,
  // tag register write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [TAG_W-1:0]  cfg_data_i
);

  logic [TAG_W-1:0] tag_q;
  logic             out_valid_q;
  res_t             out_q;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  // Tag register: always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= TAG_RESET;
    end else if (cfg_valid_i) begin
      tag_q <= cfg_data_i;
    end
  end

  // Sequencer with the slot memory and the scan unit.
  hta_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .handle_i   (handle_i),
    .user_data_i(user_data_i),
    .tag_i      (tag_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // Output register: take a new result when empty or when the current one drains.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_q.ok;
  assign handle_out_o    = out_q.handle;
  assign user_data_out_o = out_q.data;

endmodule

`default_nettype wire
